>>> hdl/client_hello_psk_truncation_finder_defines.svh
// ----------------------------------------------------------------------------
// ClientHello PSK truncation finder - assertion macros
// Immediate-style wrappers around concurrent assertions on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef CLIENT_HELLO_PSK_TRUNCATION_FINDER_DEFINES_SVH
`define CLIENT_HELLO_PSK_TRUNCATION_FINDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CHPSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CHPSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHPSK_ASSERT_NOW(lbl, ante, cons, msg)
`define CHPSK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/chpsk_pkg.sv
// ----------------------------------------------------------------------------
// chpsk_pkg
// Shared types and constants of the ClientHello PSK truncation finder.
// ----------------------------------------------------------------------------
package chpsk_pkg;

  localparam int OFFSET_BITS_DEF  = 24;
  localparam int RANDOM_BYTES_DEF = 32;
  localparam int OUT_OFFSET_W     = 24;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DTLS_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PSK_CODE  = 1'd1;

  localparam logic [15:0] PSK_CODE_RESET = 16'd41;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_COOKIE    = 2'd2;
  localparam logic [1:0] STATUS_BINDERS   = 2'd3;

  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] truncation_offset;
    logic                    psk_found;
    logic [1:0]              status;
  } result_t;

  typedef struct packed {
    logic        dtls_mode;
    logic [15:0] psk_extension_code;
  } cfg_t;

endpackage

>>> hdl/chpsk_in_reg.sv
// ----------------------------------------------------------------------------
// chpsk_in_reg
// Input word register; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module chpsk_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_last  = last_r;

endmodule

>>> hdl/chpsk_parser.sv
// ----------------------------------------------------------------------------
// chpsk_parser
// ClientHello field walker; one byte per step, result built on the last byte.
// ----------------------------------------------------------------------------
`include "client_hello_psk_truncation_finder_defines.svh"

module chpsk_parser #(
  parameter int OFFSET_BITS  = chpsk_pkg::OFFSET_BITS_DEF,
  parameter int RANDOM_BYTES = chpsk_pkg::RANDOM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  chpsk_pkg::cfg_t   cfg,
  output chpsk_pkg::result_t res
);

  typedef enum logic [24:0] {
    PH_VER      = 25'b1 << 0,
    PH_RANDOM   = 25'b1 << 1,
    PH_SID_LEN  = 25'b1 << 2,
    PH_SID      = 25'b1 << 3,
    PH_COOKIE   = 25'b1 << 4,
    PH_CS_HI    = 25'b1 << 5,
    PH_CS_LO    = 25'b1 << 6,
    PH_CS       = 25'b1 << 7,
    PH_CM_LEN   = 25'b1 << 8,
    PH_CM       = 25'b1 << 9,
    PH_EXT_HI   = 25'b1 << 10,
    PH_EXT_LO   = 25'b1 << 11,
    PH_ET_HI    = 25'b1 << 12,
    PH_ET_LO    = 25'b1 << 13,
    PH_EL_HI    = 25'b1 << 14,
    PH_EL_LO    = 25'b1 << 15,
    PH_EXT_BODY = 25'b1 << 16,
    PH_ID_HI    = 25'b1 << 17,
    PH_ID_LO    = 25'b1 << 18,
    PH_IDS      = 25'b1 << 19,
    PH_BL_HI    = 25'b1 << 20,
    PH_BL_LO    = 25'b1 << 21,
    PH_BINDERS  = 25'b1 << 22,
    PH_DONE     = 25'b1 << 23,
    PH_ERR      = 25'b1 << 24
  } phase_t;

  phase_t                 ph_r, ph_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] stop_r, stop_nxt;
  logic [15:0]            skip_r, skip_nxt;
  logic [7:0]             fhb_r, fhb_nxt;
  logic [15:0]            ebe_r, ebe_nxt;
  logic [15:0]            ets_r, ets_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   psk_r, psk_nxt;

  phase_t                 ph_w, tgt, ent;
  logic [OFFSET_BITS-1:0] pos_w, stop_w;
  logic [15:0]            skip_w, skip_dec, ebe_w, ets_w, word;
  logic [7:0]             fhb_w;
  logic [1:0]             err_w, status;
  logic                   psk_w, do_enter;
  logic [OFFSET_BITS-1:0] offset;

  assign word     = {fhb_r, data_byte};
  assign skip_dec = (skip_r != 16'd0) ? skip_r - 16'd1 : 16'd0;

  always_comb begin
    pos_w    = pos_r + OFFSET_BITS'(1);
    ph_w     = ph_r;
    stop_w   = stop_r;
    skip_w   = skip_r;
    fhb_w    = fhb_r;
    ets_w    = ets_r;
    err_w    = err_r;
    psk_w    = psk_r;
    ebe_w    = ebe_r;
    do_enter = 1'b0;
    tgt      = PH_ET_HI;
    ent      = PH_ET_HI;
    if ((ph_r == PH_ET_HI || ph_r == PH_ET_LO || ph_r == PH_EL_HI ||
         ph_r == PH_EL_LO || ph_r == PH_EXT_BODY) && ebe_r != 16'd0) begin
      ebe_w = ebe_r - 16'd1;
    end
    case (ph_r)
      PH_VER: begin
        if (pos_r != '0) begin
          skip_w = 16'(RANDOM_BYTES);
          ph_w   = PH_RANDOM;
        end
      end
      PH_RANDOM, PH_SID, PH_CS, PH_CM, PH_EXT_BODY, PH_IDS: begin
        skip_w = skip_dec;
        if (skip_dec == 16'd0) begin
          do_enter = 1'b1;
          case (ph_r)
            PH_RANDOM: tgt = PH_SID_LEN;
            PH_SID:    tgt = PH_COOKIE;
            PH_CS:     tgt = PH_CM_LEN;
            PH_CM:     tgt = PH_EXT_HI;
            PH_IDS:    tgt = PH_BL_HI;
            default:   tgt = PH_ET_HI;
          endcase
        end
      end
      PH_SID_LEN, PH_CM_LEN: begin
        if (data_byte == 8'd0) begin
          do_enter = 1'b1;
          tgt      = (ph_r == PH_SID_LEN) ? PH_COOKIE : PH_EXT_HI;
        end else begin
          skip_w = {8'd0, data_byte};
          ph_w   = (ph_r == PH_SID_LEN) ? PH_SID : PH_CM;
        end
      end
      PH_COOKIE: begin
        if (data_byte != 8'd0) begin
          err_w  = chpsk_pkg::STATUS_COOKIE;
          stop_w = pos_r;
          ph_w   = PH_ERR;
        end else begin
          do_enter = 1'b1;
          tgt      = PH_CS_HI;
        end
      end
      PH_CS_HI, PH_EXT_HI, PH_ET_HI, PH_EL_HI, PH_ID_HI, PH_BL_HI: begin
        fhb_w = data_byte;
        case (ph_r)
          PH_CS_HI:  ph_w = PH_CS_LO;
          PH_EXT_HI: ph_w = PH_EXT_LO;
          PH_ET_HI:  ph_w = PH_ET_LO;
          PH_EL_HI:  ph_w = PH_EL_LO;
          PH_ID_HI:  ph_w = PH_ID_LO;
          default:   ph_w = PH_BL_LO;
        endcase
      end
      PH_CS_LO, PH_ID_LO: begin
        if (word == 16'd0) begin
          do_enter = 1'b1;
          tgt      = (ph_r == PH_CS_LO) ? PH_CM_LEN : PH_BL_HI;
        end else begin
          skip_w = word;
          ph_w   = (ph_r == PH_CS_LO) ? PH_CS : PH_IDS;
        end
      end
      PH_EXT_LO: begin
        ebe_w    = word;
        do_enter = 1'b1;
        tgt      = PH_ET_HI;
      end
      PH_ET_LO: begin
        ets_w = word;
        ph_w  = PH_EL_HI;
      end
      PH_EL_LO: begin
        if (ets_r == cfg.psk_extension_code) begin
          psk_w = 1'b1;
          ph_w  = PH_ID_HI;
        end else if (word == 16'd0) begin
          do_enter = 1'b1;
          tgt      = PH_ET_HI;
        end else begin
          skip_w = word;
          ph_w   = PH_EXT_BODY;
        end
      end
      PH_BL_LO: begin
        skip_w = word;
        ph_w   = PH_BINDERS;
      end
      PH_BINDERS: begin
        if (skip_r == 16'd0) begin
          err_w = chpsk_pkg::STATUS_BINDERS;
          ph_w  = PH_ERR;
        end else begin
          skip_w = skip_r - 16'd1;
        end
      end
      default: begin
      end
    endcase
    if (do_enter) begin
      ent = tgt;
      if (ent == PH_COOKIE && !cfg.dtls_mode) begin
        ent = PH_CS_HI;
      end
      if (ent == PH_ET_HI && ebe_w == 16'd0) begin
        stop_w = pos_w;
        ent    = PH_DONE;
      end
      if (ent == PH_BL_HI) begin
        stop_w = pos_w;
      end
      ph_w = ent;
    end
  end

  always_comb begin
    if (err_w != chpsk_pkg::STATUS_OK) begin
      status = err_w;
      offset = stop_w;
    end else if (ph_w == PH_DONE) begin
      status = chpsk_pkg::STATUS_OK;
      offset = stop_w;
    end else if (ph_w == PH_ET_HI) begin
      status = chpsk_pkg::STATUS_OK;
      offset = pos_w;
    end else if (ph_w == PH_BINDERS) begin
      status = (skip_w == 16'd0) ? chpsk_pkg::STATUS_OK : chpsk_pkg::STATUS_BINDERS;
      offset = stop_w;
    end else begin
      status = chpsk_pkg::STATUS_TRUNCATED;
      offset = pos_w;
    end
  end

  assign res.truncation_offset = chpsk_pkg::OUT_OFFSET_W'(offset);
  assign res.psk_found         = psk_w;
  assign res.status            = status;

  always_comb begin
    if (last_byte) begin
      ph_nxt   = PH_VER;
      pos_nxt  = '0;
      stop_nxt = '0;
      skip_nxt = 16'd0;
      fhb_nxt  = 8'd0;
      ebe_nxt  = 16'd0;
      ets_nxt  = 16'd0;
      err_nxt  = chpsk_pkg::STATUS_OK;
      psk_nxt  = 1'b0;
    end else begin
      ph_nxt   = ph_w;
      pos_nxt  = pos_w;
      stop_nxt = stop_w;
      skip_nxt = skip_w;
      fhb_nxt  = fhb_w;
      ebe_nxt  = ebe_w;
      ets_nxt  = ets_w;
      err_nxt  = err_w;
      psk_nxt  = psk_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_VER;
      pos_r  <= '0;
      stop_r <= '0;
      skip_r <= 16'd0;
      fhb_r  <= 8'd0;
      ebe_r  <= 16'd0;
      ets_r  <= 16'd0;
      err_r  <= chpsk_pkg::STATUS_OK;
      psk_r  <= 1'b0;
    end else if (step) begin
      ph_r   <= ph_nxt;
      pos_r  <= pos_nxt;
      stop_r <= stop_nxt;
      skip_r <= skip_nxt;
      fhb_r  <= fhb_nxt;
      ebe_r  <= ebe_nxt;
      ets_r  <= ets_nxt;
      err_r  <= err_nxt;
      psk_r  <= psk_nxt;
    end
  end

  `CHPSK_ASSERT_NEXT(a_restart_on_last, step && last_byte, pos_r == '0 && ph_r == PH_VER, "no restart after last word")
  `CHPSK_ASSERT_NOW(a_skip_nonzero, ph_r == PH_RANDOM || ph_r == PH_SID || ph_r == PH_CS || ph_r == PH_CM || ph_r == PH_EXT_BODY || ph_r == PH_IDS, skip_r != 16'd0, "skip phase with zero count")
  `CHPSK_ASSERT_NOW(a_err_phase, err_r != chpsk_pkg::STATUS_OK, ph_r == PH_ERR, "error code outside error phase")
  `CHPSK_ASSERT_NOW(a_psk_phase, ph_r == PH_ID_HI || ph_r == PH_BL_LO || ph_r == PH_BINDERS, psk_r, "binder phases without psk")

endmodule

>>> hdl/chpsk_out_reg.sv
// ----------------------------------------------------------------------------
// chpsk_out_reg
// Result word register; loads only when the parsed word was the last one.
// ----------------------------------------------------------------------------
module chpsk_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  load_last,
  input  chpsk_pkg::result_t    res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output chpsk_pkg::result_t    out_res
);

  logic               valid_r, valid_nxt;
  chpsk_pkg::result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = load_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_last) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> hdl/client_hello_psk_truncation_finder.sv
// Path: the last word passes the input register, then the result register, to out_valid.
// Throughput: one input word per cycle unless out_valid waits on out_ready;
// one result per message, on its last word. Input feeds combinational walker.
// Reset: synchronous active-low rst_n clears handshakes and parser state,
// dtls_mode to 0 and psk_extension_code to 41.
// ----------------------------------------------------------------------------
// client_hello_psk_truncation_finder
// Finds the PSK binder truncation offset of a streamed ClientHello body.
// ----------------------------------------------------------------------------
module client_hello_psk_truncation_finder #(
  parameter int OFFSET_BITS  = chpsk_pkg::OFFSET_BITS_DEF,
  parameter int RANDOM_BYTES = chpsk_pkg::RANDOM_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [chpsk_pkg::OUT_OFFSET_W-1:0] out_truncation_offset,
  output logic                              out_psk_found,
  output logic [1:0]                        out_status,
  input  logic                              cfg_wr_en,
  input  logic [chpsk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chpsk_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

  chpsk_pkg::cfg_t    cfg_r;
  chpsk_pkg::result_t res, out_res;
  logic               held_valid, held_last, take, free;
  logic [7:0]         held_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dtls_mode          <= 1'b0;
      cfg_r.psk_extension_code <= chpsk_pkg::PSK_CODE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        chpsk_pkg::CFG_DTLS_MODE: cfg_r.dtls_mode          <= cfg_wr_data[0];
        chpsk_pkg::CFG_PSK_CODE:  cfg_r.psk_extension_code <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  assign take = held_valid && free;

  chpsk_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .take         (take),
    .held_valid   (held_valid),
    .held_byte    (held_byte),
    .held_last    (held_last)
  );

  chpsk_parser #(
    .OFFSET_BITS  (OFFSET_BITS),
    .RANDOM_BYTES (RANDOM_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .data_byte (held_byte),
    .last_byte (held_last),
    .cfg       (cfg_r),
    .res       (res)
  );

  chpsk_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .load_last (held_last),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_truncation_offset = out_res.truncation_offset;
  assign out_psk_found         = out_res.psk_found;
  assign out_status            = out_res.status;

endmodule
